// ----- hdl/mt_rng_pkg.sv -----
// Package for the bounded Mersenne Twister generator: operation codes,
// algorithm constants and the queue entry type. No dependencies.
package mt_rng_pkg;

    localparam int unsigned STATE_WORDS = 624;
    localparam int unsigned IDX_W = 10;
    localparam int unsigned SHIFT_DIST = 397;

    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;

    typedef enum logic [1:0] {
        OP_RESEED  = 2'd0,
        OP_RAW     = 2'd1,
        OP_BOUNDED = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] bound;
    } t_cmd;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] v;
        v = w ^ (w >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

endpackage

// ----- hdl/mt19937_bounded_random_generator.sv -----
// Top level of the bounded Mersenne Twister generator: seed register,
// front queue and back engine. Depends on mt_rng_pkg, mt_rng_front, mt_rng_back.
//
// Usage: write the seed on the configuration channel (valid/ready, always
// ready) while idle. Send items on the input channel (i_valid/o_stall):
// operation 0 reseeds (no result), 1 draws a raw word, 2 draws a word
// reduced below i_bound (0 means 2^32); code 3 is dropped.
// A reseed fills the 624-word state word by word. A raw draw reads the next
// state word and tempers it; every 624th draw first twists the whole state,
// reading three words for each word written, through the single read port
// of the state memory. A bounded draw adds two remainder operations in the
// serial divider, plus one draw per rejection. Results leave on
// o_valid/i_stall and are held while stalled; a two-entry queue keeps
// accepting items meanwhile. Reset sets the seed to 5489 and the word
// index to exhausted; the state memory is undefined until a reseed.
module mt19937_bounded_random_generator import mt_rng_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_bound,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value
);

    logic [31:0] r_seed;
    logic        w_cmd_valid;
    logic        w_cmd_take;
    t_cmd        w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= DEFAULT_SEED;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    mt_rng_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_operation(i_operation),
        .i_bound    (i_bound),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_take (w_cmd_take)
    );

    mt_rng_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed     (r_seed),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_take (w_cmd_take),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value)
    );

endmodule

// ----- hdl/mt_rng_front.sv -----
// Front part: accepts input transactions, drops unused codes and queues
// commands in a two-entry queue. Depends on mt_rng_pkg.
module mt_rng_front import mt_rng_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_bound,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_rd, n_rd;
    logic       r_wr, n_wr;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop, w_acc;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_acc       = i_valid && !o_stall;
    assign w_push      = w_acc && (t_op'(i_operation) != OP_UNUSED);
    assign w_pop       = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_rd  = r_rd ^ w_pop;
        n_wr  = r_wr ^ w_push;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wr] <= '{op: t_op'(i_operation), bound: i_bound};
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> o_cmd_valid) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> o_stall) else $error("full queue not stalling");

endmodule

// ----- hdl/mt_rng_divider.sv -----
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 32-bit
// divisor, remainder only. Depends on nothing.
module mt_rng_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);

    logic [32:0] r_rem;
    logic [32:0] r_dvd;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_shift;
    logic [33:0] w_sub;

    assign w_shift = {r_rem, r_dvd[32]};
    assign w_sub   = w_shift - {2'b00, r_div};
    assign o_rem   = r_rem[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_sub[33] ? w_shift[32:0] : w_sub[32:0];
                r_dvd  <= {r_dvd[31:0], 1'b0};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held high");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_rem < {1'b0, r_div})) else $error("remainder not reduced");

endmodule

// ----- hdl/mt_rng_back.sv -----
// Back part: state memory, seeding, twist, tempering and bounded reduction.
// Depends on mt_rng_pkg and mt_rng_divider.
module mt_rng_back import mt_rng_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_take,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_TW_RD0, S_TW_RD1, S_TW_RD2, S_TW_WR,
        S_DRAW, S_DRAW_W, S_LIM, S_LIM_W, S_CHECK, S_MOD, S_MOD_W, S_OUT
    } t_state;

    t_state        r_state;
    logic [31:0]   r_mem [STATE_WORDS];
    logic [31:0]   r_rdata;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_k;
    logic [31:0]   r_prev;
    logic [31:0]   r_a, r_b;
    logic [31:0]   r_word;
    logic [31:0]   r_bound;
    logic          r_bnd;
    logic [32:0]   r_limit;
    logic [31:0]   r_mult;
    logic          r_mem_we;
    logic [IDX_W-1:0] r_waddr;
    logic [31:0]   r_wdata;
    logic [IDX_W-1:0] r_raddr;
    logic          r_dstart;
    logic [32:0]   r_ddvd;
    logic          r_seeding;

    logic          w_ddone;
    logic [31:0]   w_drem;
    logic [IDX_W-1:0] w_k1, w_kf;
    logic [31:0]   w_y, w_t;
    logic [IDX_W:0]   w_kf_sum;

    assign w_k1 = (r_k == IDX_W'(STATE_WORDS - 1)) ? '0 : r_k + IDX_W'(1);
    assign w_kf_sum = {1'b0, r_k} + (IDX_W + 1)'(SHIFT_DIST);
    assign w_kf = (w_kf_sum >= (IDX_W + 1)'(STATE_WORDS))
        ? IDX_W'(w_kf_sum - (IDX_W + 1)'(STATE_WORDS)) : IDX_W'(w_kf_sum);
    assign w_y = {r_a[31], r_b[30:0]};
    assign w_t = (w_y >> 1) ^ (w_y[0] ? TWIST_MATRIX : 32'd0);
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;

    mt_rng_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_dstart),
        .i_dividend(r_ddvd),
        .i_divisor (r_bound),
        .o_done    (w_ddone),
        .o_rem     (w_drem)
    );

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_raddr];
        if (r_mem_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= IDX_W'(STATE_WORDS);
            o_valid  <= 1'b0;
            r_mem_we <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_mem_we <= 1'b0;
            r_dstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_bound <= i_cmd.bound;
                        r_bnd   <= (i_cmd.op == OP_BOUNDED) && (i_cmd.bound != '0);
                        if (i_cmd.op == OP_RESEED) begin
                            r_mem_we <= 1'b1;
                            r_waddr  <= '0;
                            r_wdata  <= i_seed;
                            r_prev   <= i_seed;
                            r_k      <= IDX_W'(1);
                            r_state  <= S_SEED;
                        end else if ((i_cmd.op == OP_BOUNDED) && (i_cmd.bound != '0)) begin
                            r_ddvd   <= 33'h1_0000_0000;
                            r_dstart <= 1'b1;
                            r_state  <= S_LIM;
                        end else begin
                            r_state <= S_DRAW;
                        end
                    end
                end
                S_SEED: begin
                    r_mult   <= r_prev ^ (r_prev >> 30);
                    r_state  <= S_TW_WR;
                end
                S_LIM: r_state <= S_LIM_W;
                S_LIM_W: begin
                    if (w_ddone) begin
                        r_limit <= 33'h1_0000_0000 - {1'b0, w_drem};
                        r_state <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    if (r_idx == IDX_W'(STATE_WORDS)) begin
                        r_k     <= '0;
                        r_raddr <= '0;
                        r_state <= S_TW_RD0;
                    end else begin
                        r_raddr <= r_idx;
                        r_state <= S_DRAW_W;
                    end
                end
                S_TW_RD0: begin
                    r_raddr <= w_k1;
                    r_state <= S_TW_RD1;
                end
                S_TW_RD1: begin
                    r_a     <= r_rdata;
                    r_raddr <= w_kf;
                    r_state <= S_TW_RD2;
                end
                S_TW_RD2: begin
                    r_b     <= r_rdata;
                    r_state <= S_TW_WR;
                end
                S_TW_WR: begin
                    r_mem_we <= 1'b1;
                    r_waddr  <= r_k;
                    if (r_seeding) begin
                        r_wdata <= INIT_MULT * r_mult + {{(32-IDX_W){1'b0}}, r_k};
                        r_prev  <= INIT_MULT * r_mult + {{(32-IDX_W){1'b0}}, r_k};
                        if (r_k == IDX_W'(STATE_WORDS - 1)) begin
                            r_idx   <= IDX_W'(STATE_WORDS);
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + IDX_W'(1);
                            r_state <= S_SEED;
                        end
                    end else begin
                        r_wdata <= r_rdata ^ w_t;
                        if (r_k == IDX_W'(STATE_WORDS - 1)) begin
                            r_idx   <= '0;
                            r_state <= S_DRAW;
                        end else begin
                            r_k     <= w_k1;
                            r_raddr <= w_k1;
                            r_state <= S_TW_RD0;
                        end
                    end
                end
                S_DRAW_W: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_word <= temper(r_rdata);
                    r_idx  <= r_idx + IDX_W'(1);
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (!r_bnd) begin
                        o_value <= r_word;
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else if ({1'b0, r_word} >= r_limit) begin
                        r_state <= S_DRAW;
                    end else begin
                        r_ddvd   <= {1'b0, r_word};
                        r_dstart <= 1'b1;
                        r_state  <= S_MOD_W;
                    end
                end
                S_MOD_W: begin
                    if (w_ddone) begin
                        o_value <= w_drem;
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeding <= 1'b0;
        end else if (r_state == S_IDLE && i_cmd_valid) begin
            r_seeding <= (i_cmd.op == OP_RESEED);
        end
    end

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT)) else $error("result outside output state");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(STATE_WORDS)) else $error("index out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value)))
        else $error("stalled result changed");

endmodule
